// ===== sv/bitmap_flip_rotate_invert_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the bitmap flip, rotate and invert core.
// Each macro expands to one labelled concurrent assertion with reset disable.
// ---------------------------------------------------------------------------
`ifndef BITMAP_FLIP_ROTATE_INVERT_CORE_ASSERT_SVH
`define BITMAP_FLIP_ROTATE_INVERT_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BFRI_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BFRI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/bfri_pkg.sv =====
// ---------------------------------------------------------------------------
// bfri_pkg
// Transform codes and control state type for the bitmap transform core.
// ---------------------------------------------------------------------------
`default_nettype none

package bfri_pkg;

  localparam int MODE_W = 3;

  localparam logic [MODE_W-1:0] MODE_FLIP_H = 3'd0;
  localparam logic [MODE_W-1:0] MODE_FLIP_V = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ROT90  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ROT180 = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ROT270 = 3'd4;
  localparam logic [MODE_W-1:0] MODE_INVERT = 3'd5;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== sv/bitmap_flip_rotate_invert_core.sv =====
// Timing: after the transaction that completes an image, the control state
// moves to emit and the first pixel passes the read data register and the
// output register before out_tvalid rises; then one result per cycle while
// out_tready is high. No new pixel is taken until the image has been read.
// Reset: rst_n (synchronous, active low) clears the pixel count, the mode
// and the control state; the image memory keeps its contents.
// ---------------------------------------------------------------------------
// bitmap_flip_rotate_invert_core
// Stores a one-bit bitmap and emits it flipped, rotated or inverted.
// ---------------------------------------------------------------------------
`default_nettype none

module bitmap_flip_rotate_invert_core #(
  parameter int IMG_WIDTH  = 8,
  parameter int IMG_HEIGHT = 8
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_tvalid,
  output logic                      in_tready,
  input  wire  [7:0]                in_tdata,   // [0] pixel_in, [7:1] zero
  output logic                      out_tvalid,
  input  wire                       out_tready,
  output logic [7:0]                out_tdata,  // [0] pixel_out, [7:1] zero
  output logic                      out_tuser,  // [0] row_end
  output logic                      out_tlast,  // image_end
  input  wire                       cfg_we,
  input  wire  [bfri_pkg::MODE_W-1:0] cfg_wdata
);

  import bfri_pkg::*;

  localparam int TOTAL = IMG_WIDTH * IMG_HEIGHT;
  localparam int AW    = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int MAXD  = (IMG_WIDTH > IMG_HEIGHT) ? IMG_WIDTH : IMG_HEIGHT;
  localparam int CW    = (MAXD > 1) ? $clog2(MAXD) : 1;

  localparam logic [AW-1:0] LOAD_LAST = AW'(TOTAL - 1);
  localparam logic [CW-1:0] W_LAST    = CW'(IMG_WIDTH - 1);
  localparam logic [CW-1:0] H_LAST    = CW'(IMG_HEIGHT - 1);

  state_t              state_r, state_nxt;
  logic [MODE_W-1:0]   cfg_mode_r;
  logic [MODE_W-1:0]   mode_r;
  logic [AW-1:0]       load_cnt_r;
  logic [CW-1:0]       row_r, col_r;

  logic                mem [TOTAL];
  logic                mem_q_r;
  logic                rd_pend_r;
  logic                pend_row_end_r, pend_img_end_r;

  logic                out_valid_r, out_pixel_r, out_row_end_r, out_img_end_r;

  logic                wr_en, load_last, emitting;
  logic                rd_issue, take_q, swap;
  logic [CW-1:0]       rows_last, cols_last, src_row, src_col;
  logic                col_last, emit_last;
  logic [AW:0]         addr_full;
  logic [AW-1:0]       rd_addr;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (wr_en && load_last) state_nxt = ST_EMIT;
      ST_EMIT: if (rd_issue && emit_last) state_nxt = ST_LOAD;
      default: state_nxt = ST_LOAD;
    endcase
  end

  // State outputs.
  always_comb begin
    in_tready = 1'b0;
    emitting  = 1'b0;
    unique case (state_r)
      ST_LOAD: in_tready = 1'b1;
      ST_EMIT: emitting  = 1'b1;
      default: in_tready = 1'b0;
    endcase
  end

  assign wr_en     = in_tvalid && in_tready;
  assign load_last = (load_cnt_r == LOAD_LAST);

  // Destination scan and source address.
  always_comb begin
    swap      = (mode_r == MODE_ROT90) || (mode_r == MODE_ROT270);
    rows_last = swap ? W_LAST : H_LAST;
    cols_last = swap ? H_LAST : W_LAST;
    col_last  = (col_r == cols_last);
    emit_last = col_last && (row_r == rows_last);
    unique case (mode_r)
      MODE_FLIP_H: begin
        src_row = row_r;
        src_col = W_LAST - col_r;
      end
      MODE_FLIP_V: begin
        src_row = H_LAST - row_r;
        src_col = col_r;
      end
      MODE_ROT90: begin
        src_row = H_LAST - col_r;
        src_col = row_r;
      end
      MODE_ROT180: begin
        src_row = H_LAST - row_r;
        src_col = W_LAST - col_r;
      end
      MODE_ROT270: begin
        src_row = col_r;
        src_col = W_LAST - row_r;
      end
      default: begin
        src_row = row_r;
        src_col = col_r;
      end
    endcase
    addr_full = (AW+1)'(src_row) * (AW+1)'(IMG_WIDTH) + (AW+1)'(src_col);
    rd_addr   = addr_full[AW-1:0];
  end

  // The read data register holds until the output register takes it, so a
  // new read is only issued when the previous data is free to move on.
  assign take_q   = rd_pend_r && (!out_valid_r || out_tready);
  assign rd_issue = emitting && (!rd_pend_r || take_q);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[load_cnt_r] <= in_tdata[0];
    end
    if (rd_issue) begin
      mem_q_r        <= mem[rd_addr];
      pend_row_end_r <= col_last;
      pend_img_end_r <= emit_last;
    end
    if (take_q) begin
      out_pixel_r   <= mem_q_r ^ (mode_r == MODE_INVERT);
      out_row_end_r <= pend_row_end_r;
      out_img_end_r <= pend_img_end_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cfg_mode_r  <= MODE_FLIP_H;
      mode_r      <= MODE_FLIP_H;
      load_cnt_r  <= '0;
      row_r       <= '0;
      col_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cfg_mode_r <= cfg_wdata;
      end
      if (wr_en) begin
        load_cnt_r <= load_last ? '0 : load_cnt_r + 1'b1;
        if (load_last) begin
          mode_r <= cfg_mode_r;
          row_r  <= '0;
          col_r  <= '0;
        end
      end
      if (rd_issue) begin
        if (col_last) begin
          col_r <= '0;
          row_r <= row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
      end
      if (rd_issue) begin
        rd_pend_r <= 1'b1;
      end else if (take_q) begin
        rd_pend_r <= 1'b0;
      end
      if (take_q) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_pixel_r};
  assign out_tuser  = out_row_end_r;
  assign out_tlast  = out_img_end_r;

`include "bitmap_flip_rotate_invert_core_assert.svh"

  `BFRI_ASSERT_SAME(a_no_rd_wr_overlap, clk, rst_n, rd_issue, !wr_en, "read and write of the image memory in one cycle")
  `BFRI_ASSERT_SAME(a_no_read_overrun, clk, rst_n, rd_pend_r && !take_q, !rd_issue, "read issued over unconsumed read data")
  `BFRI_ASSERT_SAME(a_img_end_row_end, clk, rst_n, out_tvalid && out_tlast, out_tuser, "image end without row end")
  `BFRI_ASSERT_NEXT(a_back_to_load, clk, rst_n, rd_issue && emit_last, state_r == ST_LOAD, "emit phase did not end after the last read")

endmodule

`default_nettype wire
